>>> src/amse_pkg.sv
// Shared types and constants of the alpha mask span extractor.
`timescale 1ns / 1ps
package amse_pkg;

   // Largest image dimension; counters saturate here.
   localparam int MaxDim   = 4096;
   localparam int CoordW   = 13;
   localparam int RowW     = 12;
   localparam int AlphaW   = 8;
   localparam int DataW    = 32;
   localparam int RegIdxW  = 2;
   localparam int AddrW    = RegIdxW + 2;

   localparam logic [AlphaW-1:0] AlphaOpaque = AlphaW'(255);
   localparam logic [CoordW-1:0] MaxDimCoord = CoordW'(MaxDim);

   typedef enum logic [RegIdxW-1:0] {
      REG_CLIP_LEFT   = 2'd0,
      REG_CLIP_TOP    = 2'd1,
      REG_CLIP_RIGHT  = 2'd2,
      REG_CLIP_BOTTOM = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] right;
      logic [CoordW-1:0] bottom;
   } clip_type;

   typedef struct packed {
      logic [RowW-1:0]   row;
      logic [RowW-1:0]   left;
      logic [CoordW-1:0] right;
   } span_type;

endpackage

>>> src/amse_req_if.sv
// Pixel channel: valid/ready handshake carrying one alpha byte and its flags.
`timescale 1ns / 1ps
interface amse_req_if;
   import amse_pkg::*;

   logic              valid;
   logic              ready;
   logic [AlphaW-1:0] alpha;
   logic              row_end;
   logic              image_end;

   modport source (output valid, output alpha, output row_end, output image_end,
                   input ready);
   modport sink   (input valid, input alpha, input row_end, input image_end,
                   output ready);
endinterface

>>> src/amse_rsp_if.sv
// Span channel: valid/ready handshake carrying one opaque span.
`timescale 1ns / 1ps
interface amse_rsp_if;
   import amse_pkg::*;

   logic              valid;
   logic              ready;
   logic [RowW-1:0]   span_row;
   logic [RowW-1:0]   span_left;
   logic [CoordW-1:0] span_right;

   modport source (output valid, output span_row, output span_left, output span_right,
                   input ready);
   modport sink   (input valid, input span_row, input span_left, input span_right,
                   output ready);
endinterface

>>> src/amse_csr.sv
// Clip window registers behind an APB-style write/read port.
`timescale 1ns / 1ps
module amse_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [amse_pkg::AddrW-1:0]  paddr,
   input  logic [amse_pkg::DataW-1:0]  pwdata,
   output logic [amse_pkg::DataW-1:0]  prdata,
   output logic                        pready,
   output amse_pkg::clip_type          clip
);
   import amse_pkg::*;

   clip_type    clip_ff, clip_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[AddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      clip_in = clip_ff;
      if (wr_en) begin
         unique case (idx)
            REG_CLIP_LEFT:   clip_in.left   = pwdata[CoordW-1:0];
            REG_CLIP_TOP:    clip_in.top    = pwdata[CoordW-1:0];
            REG_CLIP_RIGHT:  clip_in.right  = pwdata[CoordW-1:0];
            REG_CLIP_BOTTOM: clip_in.bottom = pwdata[CoordW-1:0];
            default:         clip_in = clip_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CLIP_LEFT:   prdata = DataW'(clip_ff.left);
         REG_CLIP_TOP:    prdata = DataW'(clip_ff.top);
         REG_CLIP_RIGHT:  prdata = DataW'(clip_ff.right);
         REG_CLIP_BOTTOM: prdata = DataW'(clip_ff.bottom);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff.left   <= '0;
         clip_ff.top    <= '0;
         clip_ff.right  <= MaxDimCoord;
         clip_ff.bottom <= MaxDimCoord;
      end else begin
         clip_ff <= clip_in;
      end
   end

   assign clip = clip_ff;

endmodule

>>> src/amse_tracker.sv
// Position counters, window test and open-run tracking for one pixel per step.
`timescale 1ns / 1ps
module amse_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [amse_pkg::AlphaW-1:0] alpha,
   input  logic                        row_end,
   input  logic                        image_end,
   input  amse_pkg::clip_type          clip,
   output logic                        emit,
   output amse_pkg::span_type          span
);
   import amse_pkg::*;

   logic [CoordW-1:0] col_ff, col_in;
   logic [CoordW-1:0] row_ff, row_in;
   logic [CoordW-1:0] start_ff, start_in;
   logic              in_span_ff, in_span_in;

   logic [CoordW-1:0] right_lim, bottom_lim, run_left, span_r;
   logic [CoordW:0]   col_next;
   logic              inwin, opaque, hit, last;

   assign right_lim  = (clip.right  > MaxDimCoord) ? MaxDimCoord : clip.right;
   assign bottom_lim = (clip.bottom > MaxDimCoord) ? MaxDimCoord : clip.bottom;
   assign inwin = (col_ff >= clip.left) && (col_ff < right_lim) &&
                  (row_ff >= clip.top)  && (row_ff < bottom_lim);
   assign opaque   = (alpha == AlphaOpaque);
   assign hit      = inwin && opaque;
   assign last     = row_end || image_end;
   assign col_next = {1'b0, col_ff} + (CoordW+1)'(1);
   assign run_left = in_span_ff ? start_ff : col_ff;

   always_comb begin
      emit       = 1'b0;
      span_r     = col_ff;
      start_in   = start_ff;
      in_span_in = in_span_ff;
      priority if (in_span_ff && !hit) begin
         // open run meets a pixel it cannot take: close before this pixel
         emit       = 1'b1;
         in_span_in = 1'b0;
      end else if (hit) begin
         start_in   = run_left;
         in_span_in = 1'b1;
         if ((col_next >= {1'b0, right_lim}) || last) begin
            emit       = 1'b1;
            span_r     = col_next[CoordW-1:0];
            in_span_in = 1'b0;
         end
      end else begin
         // nothing open and nothing to take: hold
      end
      if (image_end || row_end) begin
         in_span_in = 1'b0;
      end
   end

   assign span.row   = row_ff[RowW-1:0];
   assign span.left  = run_left[RowW-1:0];
   assign span.right = span_r;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (image_end) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         if (row_ff < MaxDimCoord) begin
            row_in = row_ff + CoordW'(1);
         end
      end else begin
         // hold the column once it has saturated
         if (col_ff < MaxDimCoord) begin
            col_in = col_next[CoordW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         start_ff   <= '0;
         in_span_ff <= 1'b0;
      end else if (step) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         start_ff   <= start_in;
         in_span_ff <= in_span_in;
      end
   end

endmodule

>>> src/alpha_mask_span_extractor_unit.sv
// Top level of the alpha mask span extractor: pixel register, tracker, span register.
`timescale 1ns / 1ps
//
//   channel   direction  beat contents
//   req_chan  in         alpha, row_end, image_end (one pixel, raster order)
//   rsp_chan  out        span_row, span_left, span_right (one opaque span)
//   csr (APB) in/out     clip_left, clip_top, clip_right, clip_bottom
//
// One pixel a cycle sustained while the span register can take each span. A
// pixel beat lands in the pixel register, is judged there by the tracker and
// its span, if any, lands in the span register as the pixel advances, so a span
// beat never leaves in the cycle its pixel beat arrives.
// Reset clears counters, open run, both valid flags and sets the full window.
// A stalled span register holds the tracker only when the pixel at its head
// would produce another span; pixels that close nothing keep flowing.
module alpha_mask_span_extractor_unit (
   input  logic                       clock,
   input  logic                       reset,
   amse_req_if.sink                   req_chan,
   amse_rsp_if.source                 rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [amse_pkg::AddrW-1:0] paddr,
   input  logic [amse_pkg::DataW-1:0] pwdata,
   output logic [amse_pkg::DataW-1:0] prdata,
   output logic                       pready
);
   import amse_pkg::*;

   clip_type          clip;
   span_type          span, span_ff, span_in;
   logic              emit, advance, out_free;
   logic              pix_valid_ff, pix_valid_in;
   logic [AlphaW-1:0] alpha_ff;
   logic              row_end_ff, image_end_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   amse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .clip    (clip)
   );

   amse_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .alpha     (alpha_ff),
      .row_end   (row_end_ff),
      .image_end (image_end_ff),
      .clip      (clip),
      .emit      (emit),
      .span      (span)
   );

   // The span register can take a beat when empty or being drained now.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // Advance the held pixel unless it carries a span with nowhere to go.
   assign advance  = pix_valid_ff && (!emit || out_free);
   assign req_chan.ready = !pix_valid_ff || advance;

   assign pix_valid_in = req_chan.valid || (pix_valid_ff && !advance);

   always_comb begin
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance && emit) begin
         span_in      = span;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: pixel fields load on a pixel beat, the span on an emitted span; both hold otherwise.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         alpha_ff     <= req_chan.alpha;
         row_end_ff   <= req_chan.row_end;
         image_end_ff <= req_chan.image_end;
      end
      span_ff <= span_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.span_row   = span_ff.row;
   assign rsp_chan.span_left  = span_ff.left;
   assign rsp_chan.span_right = span_ff.right;

endmodule

>>> sim/amse_span_checker.sv
// Span checker: watches the pixel, span and register ports, predicts spans and compares.
`timescale 1ns / 1ps
module amse_span_checker
   import amse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   amse_req_if              req_mon,
   amse_rsp_if              rsp_mon,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [DataW-1:0] pwdata,
   input  logic             pready,
   output int               mismatches,
   output int               spans_pending,
   output int               spans_seen
);

   clip_type          window;
   logic [CoordW-1:0] col_pos;
   logic [CoordW-1:0] row_pos;
   logic [CoordW-1:0] run_first;
   logic              run_open;
   span_type          span_q[$];
   int                miss_count;
   int                seen_count;

   assign mismatches = miss_count;
   assign spans_seen = seen_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (miss_count < 20) begin
         $display("[%0t] span mismatch: %s got %0d want %0d", $realtime, what, got, want);
      end
      miss_count++;
   endtask

   // Judge one pixel against the clip window and advance the raster position.
   task automatic judge_pixel(input logic [AlphaW-1:0] alpha, input logic row_end,
                              input logic image_end);
      int       col;
      int       row;
      int       right;
      int       bottom;
      bit       in_window;
      bit       opaque;
      bit       emit;
      span_type s;
      col       = col_pos;
      row       = row_pos;
      right     = (window.right < MaxDimCoord) ? window.right : MaxDim;
      bottom    = (window.bottom < MaxDimCoord) ? window.bottom : MaxDim;
      in_window = col >= window.left && col < right && row >= window.top && row < bottom;
      opaque    = (alpha == AlphaOpaque);
      emit      = 1'b0;
      s         = '0;
      if (run_open && !(in_window && opaque)) begin
         s.left   = RowW'(run_first);
         s.right  = CoordW'(col);
         run_open = 1'b0;
         emit     = 1'b1;
      end else if (in_window && opaque) begin
         if (!run_open) begin
            run_first = CoordW'(col);
            run_open  = 1'b1;
         end
         if (col + 1 >= right || row_end || image_end) begin
            s.left   = RowW'(run_first);
            s.right  = CoordW'(col + 1);
            run_open = 1'b0;
            emit     = 1'b1;
         end
      end
      if (emit) begin
         s.row = RowW'(row);
         span_q.push_back(s);
      end
      if (image_end) begin
         col_pos  = '0;
         row_pos  = '0;
         run_open = 1'b0;
      end else if (row_end) begin
         col_pos  = '0;
         run_open = 1'b0;
         if (row_pos < MaxDimCoord) row_pos = row_pos + 1'b1;
      end else if (col_pos < MaxDimCoord) begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   task automatic compare_span();
      span_type want;
      if (span_q.size() == 0) begin
         report_mismatch("unexpected span, row", rsp_mon.span_row, -1);
      end else begin
         want = span_q.pop_front();
         if (rsp_mon.span_row !== want.row)
            report_mismatch("span_row", rsp_mon.span_row, want.row);
         if (rsp_mon.span_left !== want.left)
            report_mismatch("span_left", rsp_mon.span_left, want.left);
         if (rsp_mon.span_right !== want.right)
            report_mismatch("span_right", rsp_mon.span_right, want.right);
      end
      seen_count++;
   endtask

   initial begin
      miss_count    = 0;
      seen_count    = 0;
      spans_pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         window    = '{left: '0, top: '0, right: MaxDimCoord, bottom: MaxDimCoord};
         col_pos   = '0;
         row_pos   = '0;
         run_first = '0;
         run_open  = 1'b0;
         span_q.delete();
      end else begin
         // Compare first: a span never leaves in the cycle its pixel arrives.
         if (rsp_mon.valid && rsp_mon.ready) compare_span();
         if (req_mon.valid && req_mon.ready)
            judge_pixel(req_mon.alpha, req_mon.row_end, req_mon.image_end);
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[AddrW-1:2]))
               REG_CLIP_LEFT:   window.left   = pwdata[CoordW-1:0];
               REG_CLIP_TOP:    window.top    = pwdata[CoordW-1:0];
               REG_CLIP_RIGHT:  window.right  = pwdata[CoordW-1:0];
               REG_CLIP_BOTTOM: window.bottom = pwdata[CoordW-1:0];
               default: ;
            endcase
         end
      end
      spans_pending <= span_q.size();
   end

endmodule

>>> sim/alpha_mask_span_extractor_unit_tb.sv
// Testbench top: pixel stimulus, span receiver, clip register writes and the verdict.
`timescale 1ns / 1ps
module alpha_mask_span_extractor_unit_tb;
   import amse_pkg::*;

   logic             clock;
   logic             reset;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [AddrW-1:0] paddr;
   logic [DataW-1:0] pwdata;
   logic [DataW-1:0] prdata;
   logic             pready;

   amse_req_if req_chan ();
   amse_rsp_if rsp_chan ();

   int mismatches;
   int spans_pending;
   int spans_seen;

   // Stimulus bookkeeping.
   int pixels_sent;
   int settings_applied;
   int send_idle_pct;
   int recv_stall_pct;
   bit opaque_streak;

   // Long receiver hold-off: the stimulus asks, the receiver process counts it out.
   int hold_asked;
   int hold_done;
   int hold_left;

   alpha_mask_span_extractor_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   amse_span_checker span_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .mismatches    (mismatches),
      .spans_pending (spans_pending),
      .spans_seen    (spans_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legitimate run.
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // Span receiver: random stalls per phase, plus the long hold-off on request.
   initial begin
      hold_done = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (hold_asked != hold_done) begin
            hold_done      = hold_asked;
            hold_left      = 400;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Pick the idling pattern: none, sender idle, receiver stalling, or both lightly.
   task automatic set_idle(input int mode);
      case (mode)
         1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
         3:       begin send_idle_pct = 11; recv_stall_pct = 11; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Offer one pixel beat, with random idle cycles ahead of it; return at acceptance.
   // Valid is left high so that a following beat can ride the next cycle.
   task automatic push_pixel(input logic [AlphaW-1:0] alpha, input logic row_end,
                             input logic image_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.alpha     <= alpha;
      req_chan.row_end   <= row_end;
      req_chan.image_end <= image_end;
      do @(posedge clock); while (!req_chan.ready);
      pixels_sent++;
   endtask

   // Drop valid, then wait for every predicted span and let the pipeline empty.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (spans_pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Setup phase, access phase, then a quiet gap with psel low so writes never overlap.
   task automatic write_reg(input reg_idx_type idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= DataW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input int left, input int top, input int right, input int bottom);
      settle();
      write_reg(REG_CLIP_LEFT, left);
      write_reg(REG_CLIP_TOP, top);
      write_reg(REG_CLIP_RIGHT, right);
      write_reg(REG_CLIP_BOTTOM, bottom);
      settings_applied++;
   endtask

   // Alpha in streaks: opaque runs of random length between mixed translucent pixels.
   function automatic logic [AlphaW-1:0] pick_alpha();
      if ($urandom_range(99) < 30) opaque_streak = !opaque_streak;
      if (opaque_streak) return AlphaOpaque;
      case ($urandom_range(3))
         0:       return '0;
         1:       return AlphaW'(254);
         default: return AlphaW'($urandom_range(0, 254));
      endcase
   endfunction

   // One image in raster order; noise breaks row lengths and scatters stray flags.
   task automatic send_image(input int max_w, input int max_h, input int noise);
      int   w;
      int   h;
      logic row_end;
      logic image_end;
      w = $urandom_range(1, max_w);
      h = $urandom_range(1, max_h);
      for (int r = 0; r < h; r++) begin
         if ($urandom_range(99) < noise) w = $urandom_range(1, max_w);
         for (int c = 0; c < w; c++) begin
            row_end   = (c == w - 1);
            image_end = row_end && (r == h - 1);
            if ($urandom_range(99) < noise) begin
               row_end   = $urandom_range(1);
               image_end = ($urandom_range(3) == 0);
            end
            push_pixel(pick_alpha(), row_end, image_end);
         end
      end
   endtask

   initial begin
      int target;

      pixels_sent      = 0;
      settings_applied = 0;
      hold_asked       = 0;
      opaque_streak    = 1'b0;
      set_idle(0);

      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.alpha     <= '0;
      req_chan.row_end   <= 1'b0;
      req_chan.image_end <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: narrow window, columns 2..5 and rows 0..2.
      set_window(2, 0, 6, 3);
      // Row 0: opaque left of the window, a run closed by a clear pixel, a run
      // closed by the right clip edge, then opaque pixels beyond it.
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel('0, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b1, 1'b0);
      // Row 1: run closed by the row end.
      push_pixel('0, 1'b0, 1'b0);
      push_pixel('0, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b1, 1'b0);
      // Row 2: near-opaque and other non-opaque values, then a single pixel closed by the image end.
      push_pixel(AlphaW'(254), 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaW'(1), 1'b0, 1'b0);
      push_pixel(AlphaW'(128), 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b1);

      // Directed: open a run, pull the right edge in under it, and let the next
      // pixel (now outside) close it.
      set_window(0, 0, MaxDim, MaxDim);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      settle();
      write_reg(REG_CLIP_RIGHT, 3);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b1, 1'b1);

      // Directed: empty window, opaque pixels give nothing.
      set_window(5, 0, 5, MaxDim);
      push_pixel(AlphaOpaque, 1'b0, 1'b0);
      push_pixel(AlphaOpaque, 1'b1, 1'b1);

      // Random phases: small images under varied windows, cycling the idling
      // patterns so that gaps land on every stage of the pipeline.
      for (int ph = 0; ph < 8; ph++) begin
         set_idle(ph % 4);
         case (ph)
            0: set_window(0, 0, MaxDim, MaxDim);
            2: set_window(MaxDim, MaxDim, 0, 0);
            5: set_window(0, 0, 1, 1);
            default: set_window($urandom_range(0, 10), $urandom_range(0, 4),
                                $urandom_range(0, 40), $urandom_range(0, 12));
         endcase
         target = pixels_sent + 65;
         while (pixels_sent < target) send_image(32, 8, 6);
      end

      // Back-pressure: hold the receiver off for a long stretch while dense
      // opaque/clear pixels keep coming, so the span register fills and the
      // pixel side stalls.
      set_idle(0);
      set_window(0, 0, MaxDim, MaxDim);
      hold_asked++;
      for (int i = 0; i < 150; i++) begin
         push_pixel((i % 2 == 0) ? AlphaOpaque : AlphaW'(0), (i % 16 == 15), (i == 149));
      end

      // Drain: every predicted span must arrive, then give stragglers time to show.
      set_idle(0);
      settle();
      repeat (10) @(posedge clock);

      $display("Run covered %0d pixel beats and %0d span beats over %0d clip settings,",
               pixels_sent, spans_seen, settings_applied);
      $display("including edge clipping, empty windows, clip changes and long stalls.");
      if (mismatches == 0 && spans_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/amse_pkg.sv
src/amse_req_if.sv
src/amse_rsp_if.sv
src/amse_csr.sv
src/amse_tracker.sv
src/alpha_mask_span_extractor_unit.sv
sim/amse_span_checker.sv
sim/alpha_mask_span_extractor_unit_tb.sv
